>>> rtl/lse_pkg.sv
`default_nettype none

package lse_pkg;

    localparam int DEPTH   = 32;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int COUNT_W = 6;
    localparam int STAT_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_PEEK     = 3'd2,
        OP_SIZE     = 3'd3,
        OP_CLEAR    = 3'd4,
        OP_TRAVERSE = 3'd5
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_TRAV
    } t_state;

    // Read address select for the stack memory.
    typedef enum logic [1:0] {
        RD_TOP,
        RD_ZERO,
        RD_IDX,
        RD_NEXT
    } t_rd_sel;

    typedef struct packed {
        logic    push;
        logic    pop;
        logic    clear;
        t_rd_sel rd_sel;
        logic    idx_clr;
        logic    idx_inc;
        logic    out_load;
        logic    out_rdata;
        t_status out_status;
        logic    out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic idx_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/lse_if.sv
`default_nettype none

interface lse_in_if
    import lse_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic        [OP_W-1:0]   op;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface lse_out_if
    import lse_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data;
    logic        [COUNT_W-1:0] count;
    logic        [STAT_W-1:0] status;
    logic                     last;

    modport source (output valid, output data, output count, output status,
                    output last, input ready);
    modport sink   (input valid, input data, input count, input status,
                    input last, output ready);
endinterface

`default_nettype wire

>>> rtl/lse_ctrl.sv
`default_nettype none

module lse_ctrl
    import lse_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [OP_W-1:0] i_op,
    input  wire t_dp_sts         i_sts,
    output t_dp_cmd              o_cmd,
    output logic                 o_ready
);

    t_state r_state;
    t_state n_state;
    logic   w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Same condition as valid and ready while idle, taken from the status
    // directly so that the decode below does not depend on its own output.
    assign w_fire = i_valid && i_sts.out_free && (r_state == S_IDLE);

    always_comb begin
        n_state          = r_state;
        o_ready          = 1'b0;
        o_cmd            = '0;
        o_cmd.rd_sel     = RD_TOP;
        o_cmd.out_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_ready = i_sts.out_free;
                if (w_fire) begin
                    o_cmd.out_last = 1'b1;
                    unique case (i_op)
                        OP_PUSH: begin
                            o_cmd.out_load = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.out_status = ST_OVERFLOW;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (i_sts.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_EMPTY;
                            end else begin
                                o_cmd.pop = (i_op == OP_POP);
                                n_state   = S_READ;
                            end
                        end
                        OP_CLEAR: begin
                            o_cmd.clear    = 1'b1;
                            o_cmd.out_load = 1'b1;
                        end
                        OP_TRAVERSE: begin
                            if (i_sts.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_EMPTY;
                            end else begin
                                o_cmd.rd_sel  = RD_ZERO;
                                o_cmd.idx_clr = 1'b1;
                                n_state       = S_TRAV;
                            end
                        end
                        default: begin
                            o_cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                // The output slot was free when the request was taken.
                o_cmd.out_load  = 1'b1;
                o_cmd.out_rdata = 1'b1;
                o_cmd.out_last  = 1'b1;
                n_state         = S_IDLE;
            end
            S_TRAV: begin
                o_cmd.rd_sel = RD_IDX;
                if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_rdata = 1'b1;
                    o_cmd.out_last  = i_sts.idx_last;
                    if (i_sts.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        o_cmd.rd_sel  = RD_NEXT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/lse_dp.sv
`default_nettype none

module lse_dp
    import lse_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic                     i_out_ready,
    output t_dp_sts                       o_sts,
    output logic                          o_out_valid,
    output logic signed [DATA_W-1:0]      o_out_data,
    output logic        [COUNT_W-1:0]     o_out_count,
    output logic        [STAT_W-1:0]      o_out_status,
    output logic                          o_out_last
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;
    logic        [CNT_W-1:0]  r_count;
    logic        [CNT_W-1:0]  n_count;
    logic        [ADDR_W-1:0] r_idx;
    logic        [ADDR_W-1:0] w_top;
    logic        [ADDR_W-1:0] w_rd_addr;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_data;
    logic        [COUNT_W-1:0] r_out_count;
    logic        [STAT_W-1:0] r_out_status;
    logic                     r_out_last;

    assign w_top = ADDR_W'(r_count - 1'b1);

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.push) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_TOP:  w_rd_addr = w_top;
            RD_ZERO: w_rd_addr = '0;
            RD_IDX:  w_rd_addr = r_idx;
            RD_NEXT: w_rd_addr = r_idx + 1'b1;
            default: w_rd_addr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[ADDR_W'(r_count)] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_data   <= i_cmd.out_rdata ? r_rdata : '0;
            r_out_count  <= COUNT_W'(n_count);
            r_out_status <= i_cmd.out_status;
            r_out_last   <= i_cmd.out_last;
        end
    end

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CNT_W'(DEPTH));
    assign o_sts.idx_last = (r_idx == w_top);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_out_count  = r_out_count;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule

`default_nettype wire

>>> rtl/lifo_stack_engine.sv
// LIFO stack of DEPTH signed 32-bit words behind two valid/ready channels.
// Each request on i_in carries an op (push, pop, peek, size, clear, traverse)
// and a value that only push uses. Every request gives one result on o_out,
// except traverse of a non-empty stack, which streams every held word from
// bottom to top, raising last on the final one; other results raise last.
// Push, size, clear and every error load their result into the output
// register as the request is taken. Pop and peek read the stack memory,
// whose read port is registered, so their result passes through the read
// register and then the output register. Traverse first reads the bottom
// entry and then delivers one word per cycle while the output is free.
// A new request is taken only while the controller is idle and the output
// register is empty or being drained in the same cycle, so push, size and
// clear run at one request per cycle while results drain; after a pop or
// peek the next request waits for its result. If the receiver stalls, the
// result waits in the output register and the stack takes no further
// request; a stalled traverse re-reads the same entry until it is taken.
// Reset empties the stack and the output register; memory contents are not
// cleared since an entry is only read after it has been pushed.

`default_nettype none

module lifo_stack_engine
    import lse_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lse_in_if.sink    i_in,
    lse_out_if.source o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller sequences each request and raises ready only when idle.
    lse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_op    (i_in.op),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_ready (i_in.ready)
    );

    // The datapath holds the stack memory, the entry count, the traverse
    // index and the output register.
    lse_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_value      (i_in.value),
        .i_out_ready  (o_out.ready),
        .o_sts        (w_sts),
        .o_out_valid  (o_out.valid),
        .o_out_data   (o_out.data),
        .o_out_count  (o_out.count),
        .o_out_status (o_out.status),
        .o_out_last   (o_out.last)
    );

endmodule

`default_nettype wire

>>> dv/lse_stack_checker.sv
module lse_stack_checker
    import lse_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lse_in_if         i_req,
    lse_out_if        i_rsp,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_requests,
    output int        o_results,
    output int        o_overflows,
    output int        o_empties,
    output int        o_longest_traverse
);

    typedef struct packed {
        logic signed [DATA_W-1:0]  data;
        logic        [COUNT_W-1:0] count;
        t_status                   status;
        logic                      last;
    } t_stack_result;

    // Shadow copy of the stack contents and fill level.
    logic signed [DATA_W-1:0] stack_words [DEPTH];
    int unsigned              words_held;
    t_stack_result            awaited_results [$];

    function automatic void await_result(input logic signed [DATA_W-1:0] data,
                                         input t_status status, input logic last);
        t_stack_result res;
        res.data   = data;
        res.count  = COUNT_W'(words_held);
        res.status = status;
        res.last   = last;
        awaited_results.push_back(res);
        if (status == ST_OVERFLOW) o_overflows++;
        if (status == ST_EMPTY) o_empties++;
    endfunction

    function automatic void predict_request(input logic [OP_W-1:0] op,
                                            input logic signed [DATA_W-1:0] value);
        o_requests++;
        case (op)
            OP_PUSH: begin
                if (words_held == DEPTH) begin
                    await_result('0, ST_OVERFLOW, 1'b1);
                end else begin
                    stack_words[words_held] = value;
                    words_held++;
                    await_result('0, ST_OK, 1'b1);
                end
            end
            OP_POP: begin
                if (words_held == 0) begin
                    await_result('0, ST_EMPTY, 1'b1);
                end else begin
                    words_held--;
                    await_result(stack_words[words_held], ST_OK, 1'b1);
                end
            end
            OP_PEEK: begin
                if (words_held == 0) await_result('0, ST_EMPTY, 1'b1);
                else await_result(stack_words[words_held-1], ST_OK, 1'b1);
            end
            OP_CLEAR: begin
                words_held = 0;
                await_result('0, ST_OK, 1'b1);
            end
            OP_TRAVERSE: begin
                if (words_held == 0) begin
                    await_result('0, ST_EMPTY, 1'b1);
                end else begin
                    // Bottom of the stack comes out first.
                    for (int unsigned i = 0; i < words_held; i++)
                        await_result(stack_words[i], ST_OK, i + 1 == words_held);
                    if (words_held > o_longest_traverse) o_longest_traverse = words_held;
                end
            end
            // Size and the unused codes change nothing and return no data.
            default: await_result('0, ST_OK, 1'b1);
        endcase
    endfunction

    function automatic void check_result(input logic signed [DATA_W-1:0] data,
                                         input logic [COUNT_W-1:0] count,
                                         input logic [STAT_W-1:0] status,
                                         input logic last);
        t_stack_result want;
        o_results++;
        if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, data %0d count %0d status %0d last %0d",
                     $time, data, count, status, last);
            o_fail_count++;
            return;
        end
        want = awaited_results.pop_front();
        if (data !== want.data) begin
            $display("%0t: data mismatch, expected %0d, actual %0d", $time, want.data, data);
            o_fail_count++;
        end
        if (count !== want.count) begin
            $display("%0t: count mismatch, expected %0d, actual %0d",
                     $time, want.count, count);
            o_fail_count++;
        end
        if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
            o_fail_count++;
        end
        if (last !== want.last) begin
            $display("%0t: last mismatch, expected %0d, actual %0d", $time, want.last, last);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            words_held         = 0;
            awaited_results    = {};
            o_fail_count       = 0;
            o_requests         = 0;
            o_results          = 0;
            o_overflows        = 0;
            o_empties          = 0;
            o_longest_traverse = 0;
        end else begin
            // A result always trails its request, so check before predicting.
            if (i_rsp.valid && i_rsp.ready)
                check_result(i_rsp.data, i_rsp.count, i_rsp.status, i_rsp.last);
            if (i_req.valid && i_req.ready)
                predict_request(i_req.op, i_req.value);
        end
        o_pending = awaited_results.size();
    end

endmodule

>>> dv/lifo_stack_engine_tb.sv
module lifo_stack_engine_tb;
    import lse_pkg::*;

    // The op field is three bits wide, so two codes have no operation behind
    // them. The block must answer them without touching the stack.
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    // The slowest correct run is roughly 170 requests, each streaming a full
    // stack of 32 words that each wait out the longest random receiver stall.
    // RUN_LIMIT is set well above that.
    localparam int RUN_LIMIT        = 500_000;
    localparam int MAX_BURST        = 15;
    localparam int LONG_HOLD_CYCLES = 300;
    // Long enough for a full traverse of DEPTH words to finish.
    localparam int SETTLE_CYCLES    = DEPTH + 8;

    // Shapes of random request streams. Filling mostly pushes so the stack
    // reaches full and overflows; draining mostly pops so it runs empty.
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_ANY
    } t_mix;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        idling_on;
    logic        long_hold_pending;
    int unsigned cycle_count;

    int fail_count;
    int pending;
    int requests;
    int results;
    int overflows;
    int empties;
    int longest_traverse;

    lse_in_if  req_bus ();
    lse_out_if rsp_bus ();

    lifo_stack_engine dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_bus),
        .o_out   (rsp_bus)
    );

    // The checker sits beside the block, watches both channels, keeps its
    // own copy of the stack and compares every result as it is taken.
    lse_stack_checker stack_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_req              (req_bus),
        .i_rsp              (rsp_bus),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_requests         (requests),
        .o_results          (results),
        .o_overflows        (overflows),
        .o_empties          (empties),
        .o_longest_traverse (longest_traverse)
    );

    always #10 clk = ~clk;

    // Offer one request and hold it until the block takes it. The task
    // returns at the accepting edge with valid still high, so a request that
    // follows straight away keeps valid up and only changes the payload;
    // valid is lowered only when a gap is inserted or the stream ends.
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [DATA_W-1:0] value);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.op    <= op;
        req_bus.value <= value;
        do @(posedge clk); while (!req_bus.ready);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input t_mix mix);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                // No pops or clears here, so the stack only grows towards full.
                if (roll < 88) return OP_PUSH;
                else if (roll < 92) return OP_PEEK;
                else if (roll < 96) return OP_SIZE;
                else return OP_TRAVERSE;
            end
            MIX_DRAIN: begin
                if (roll < 80) return OP_POP;
                else if (roll < 86) return OP_PEEK;
                else if (roll < 90) return OP_TRAVERSE;
                else if (roll < 94) return OP_SIZE;
                else if (roll < 97) return OP_UNUSED_6;
                else return OP_UNUSED_7;
            end
            default: return OP_W'($urandom_range(0, (1 << OP_W) - 1));
        endcase
    endfunction

    // Mostly random words, with the signed extremes, zero and minus one
    // mixed in so that corner values travel through push, pop and traverse.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(DATA_W-1){1'b1}}};
            1:       return {1'b1, {(DATA_W-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic run_mix(input t_mix mix, input int n_requests);
        repeat (n_requests) send_request(pick_op(mix), pick_value());
    endtask

    // Stimulus: reset, a short directed walk through every operation and the
    // empty cases, then shaped random streams. The verdict is given here.
    initial begin : stimulus
        rst_n             <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.op        <= OP_SIZE;
        req_bus.value     <= '0;
        idling_on         <= 1'b1;
        long_hold_pending <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Pop, peek and traverse on an empty stack must report empty; size reports zero.
        send_request(OP_POP, '0);
        send_request(OP_PEEK, '0);
        send_request(OP_TRAVERSE, '0);
        send_request(OP_SIZE, '0);
        // Push the extremes and alternating bit patterns so that every bit
        // of the value field is seen both high and low.
        send_request(OP_PUSH, {1'b0, {(DATA_W-1){1'b1}}});
        send_request(OP_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
        send_request(OP_PUSH, '0);
        send_request(OP_PUSH, '1);
        send_request(OP_PUSH, 32'h5555_5555);
        send_request(OP_PUSH, 32'hAAAA_AAAA);
        send_request(OP_PEEK, '0);
        send_request(OP_SIZE, '0);
        send_request(OP_TRAVERSE, '0);
        send_request(OP_POP, '0);
        send_request(OP_POP, '0);
        // The unused codes must leave the stack alone.
        send_request(OP_UNUSED_6, '1);
        send_request(OP_UNUSED_7, '1);
        send_request(OP_CLEAR, '0);
        send_request(OP_SIZE, '0);
        send_request(OP_POP, '0);
        // A traverse of a single entry raises last on its only result.
        send_request(OP_PUSH, 32'sd1);
        send_request(OP_TRAVERSE, '0);

        // The receiver holds off for a long stretch while the stack fills,
        // so the output register stays occupied and the block refuses input.
        long_hold_pending <= 1'b1;
        run_mix(MIX_FILL, 50);
        run_mix(MIX_DRAIN, 45);
        run_mix(MIX_ANY, 35);
        // The last part runs back to back on both sides.
        idling_on <= 1'b0;
        run_mix(MIX_ANY, 20);
        req_bus.valid <= 1'b0;

        // Wait at the falling edge so the checker's count is settled.
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d requests: %0d overflowed pushes, %0d empty errors.",
                 results, requests, overflows, empties);
        $display("Longest traverse was %0d entries, with a %0d-cycle receiver hold-off.",
                 longest_traverse, LONG_HOLD_CYCLES);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("lifo_stack_engine_tb passed");
        end else begin
            $display("lifo_stack_engine_tb failed");
        end
        $finish;
    end

    // The receiver accepts most cycles, stalls in random bursts while idling
    // is on, and serves the one long hold-off when the stimulus asks for it.
    initial begin : receiver
        rsp_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (long_hold_pending) begin
                long_hold_pending <= 1'b0;
                rsp_bus.ready     <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end else if (idling_on && $urandom_range(0, 11) == 0) begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
            end else begin
                rsp_bus.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // A hung handshake ends the run here.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run exceeded %0d cycles", $time, RUN_LIMIT);
        $display("lifo_stack_engine_tb failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/lse_pkg.sv
rtl/lse_if.sv
rtl/lse_ctrl.sv
rtl/lse_dp.sv
rtl/lifo_stack_engine.sv
dv/lse_stack_checker.sv
dv/lifo_stack_engine_tb.sv
